/* hdl/mof_pkg.sv */
// Package with the shared constants, types and state codes of the median outlier filter.
`default_nettype none
package mof_pkg;

  localparam int MAX_SAMPLES    = 32;
  localparam int SAMPLE_W       = 16;
  localparam int DEV_W          = 16;
  localparam int IDX_W          = $clog2(MAX_SAMPLES);
  localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
  localparam int NUM_BANKS      = 2;
  localparam int BANK_W         = $clog2(NUM_BANKS);
  localparam int RAM_DEPTH      = NUM_BANKS * MAX_SAMPLES;
  localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
  localparam int JOB_FIFO_DEPTH = NUM_BANKS;
  localparam int JQ_PTR_W       = $clog2(JOB_FIFO_DEPTH);
  localparam int JQ_FILL_W      = $clog2(JOB_FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [BANK_W-1:0]          bank_t;
  typedef logic [RAM_ADDR_W-1:0]      ram_addr_t;

  // One loaded set, handed from the loader to the emitter.
  typedef struct packed {
    bank_t   bank;
    cnt_t    count;
    sample_t median;
    logic    ovf;
  } job_t;

  // Write port of the arrival store.
  typedef struct packed {
    logic      we;
    ram_addr_t addr;
    sample_t   data;
  } wr_t;

  // Emitter tells the loader that a bank has been fully read out.
  typedef struct packed {
    logic  done;
    bank_t bank;
  } release_t;

  typedef enum logic [1:0] {
    F_LOAD   = 2'b01,
    F_MEDIAN = 2'b10
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_RUN   = 3'b010,
    B_FLUSH = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

/* hdl/mof_if.sv */
// Stream interfaces for the sample input channel and the result output channel.
`default_nettype none
interface mof_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      sample;
  logic                    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mof_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      kept_sample;
  logic signed [15:0]      median_value;
  logic                    end_of_run;
  logic                    none_kept;
  logic                    overflowed;

  modport source (output valid, output kept_sample, output median_value,
                  output end_of_run, output none_kept, output overflowed, input ready);
  modport sink   (input valid, input kept_sample, input median_value,
                  input end_of_run, input none_kept, input overflowed, output ready);
endinterface
`default_nettype wire

/* hdl/mof_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mof_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/mof_front.sv */
// Loader: takes samples, writes them to the arrival store and keeps a sorted cell chain.
`default_nettype none
module mof_front (
  input  logic              clk,
  input  logic              rst,
  mof_in_if.sink            in_stream,
  output mof_pkg::wr_t      ram_wr,
  output mof_pkg::job_t     job,
  output logic              job_push,
  input  logic              job_full,
  input  mof_pkg::release_t rel
);
  import mof_pkg::*;

  front_state_t          state;
  sample_t               cells [MAX_SAMPLES];
  sample_t               cells_next [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] lt;
  cnt_t                  count;
  logic                  ovf;
  bank_t                 wbank;
  logic [NUM_BANKS-1:0]  bank_busy;
  logic                  accept;
  logic                  store;
  idx_t                  med_idx;

  assign in_stream.ready = (state == F_LOAD) && !bank_busy[wbank];
  assign accept          = in_stream.valid && in_stream.ready;
  assign store           = accept && (count < CNT_W'(MAX_SAMPLES));

  // Arrival order goes straight into the current bank.
  assign ram_wr.we   = store;
  assign ram_wr.addr = {wbank, count[IDX_W-1:0]};
  assign ram_wr.data = in_stream.sample;

  // Insertion: cells below the new value stay, the rest shift up by one.
  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      lt[i] = (CNT_W'(i) < count) && (cells[i] < in_stream.sample);
    end
    cells_next[0] = lt[0] ? cells[0] : in_stream.sample;
    for (int i = 1; i < MAX_SAMPLES; i++) begin
      if (lt[i]) begin
        cells_next[i] = cells[i];
      end else if (lt[i-1]) begin
        cells_next[i] = in_stream.sample;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  // The median is read in the median state that follows the last sample, once the chain has settled.
  assign med_idx    = IDX_W'(count >> 1);
  assign job.bank   = wbank;
  assign job.count  = count;
  assign job.median = cells[med_idx];
  assign job.ovf    = ovf;
  assign job_push   = (state == F_MEDIAN) && !job_full;

  // Sorted chain has no reset; only entries below the count are ever used.
  always_ff @(posedge clk) begin
    if (store) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // Load sequencing and bank ownership.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      wbank     <= '0;
      bank_busy <= '0;
    end else begin
      case (state)
        F_LOAD: begin
          if (accept) begin
            if (store) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (in_stream.last_sample) begin
              state <= F_MEDIAN;
            end
          end
        end
        F_MEDIAN: begin
          if (job_push) begin
            count <= '0;
            ovf   <= 1'b0;
            wbank <= wbank + 1'b1;
            state <= F_LOAD;
          end
        end
        default: begin
          state <= F_LOAD;
        end
      endcase

      for (int b = 0; b < NUM_BANKS; b++) begin
        if (job_push && (wbank == BANK_W'(b))) begin
          bank_busy[b] <= 1'b1;
        end else if (rel.done && (rel.bank == BANK_W'(b))) begin
          bank_busy[b] <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/mof_job_fifo.sv */
// Short queue of loaded sets between the loader and the emitter.
`default_nettype none
module mof_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mof_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output mof_pkg::job_t head,
  output logic          empty
);
  import mof_pkg::*;

  job_t                  entries [JOB_FIFO_DEPTH];
  logic [JQ_PTR_W-1:0]   wptr;
  logic [JQ_PTR_W-1:0]   rptr;
  logic [JQ_FILL_W-1:0]  fill;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (fill == JQ_FILL_W'(JOB_FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign head    = entries[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == JQ_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == JQ_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/mof_back.sv */
// Emitter: reads a set back in arrival order and passes on the samples near the median.
`default_nettype none
module mof_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,
  input  mof_pkg::job_t              job,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       ram_re,
  output mof_pkg::ram_addr_t         ram_raddr,
  input  mof_pkg::sample_t           ram_rdata,
  output mof_pkg::release_t          rel,
  mof_out_if.source                  out_stream
);
  import mof_pkg::*;

  back_state_t          state;
  logic [DEV_W-1:0]     max_deviation;
  job_t                 cur;
  cnt_t                 idx;
  logic                 data_vld;
  logic                 pend_vld;
  sample_t              pend_sample;
  logic                 out_vld;
  sample_t              out_sample;
  sample_t              out_median;
  logic                 out_eor;
  logic                 out_nk;
  logic                 out_ovf;
  logic                 out_free;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]    abs_diff;
  logic                 kept;
  logic                 stall;
  logic                 more;
  logic                 push_pend;
  logic                 push_last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_deviation <= '0;
    end else if (cfg_we) begin
      max_deviation <= cfg_wdata;
    end
  end

  // Distance test on the sample returned by the store.
  assign diff     = {ram_rdata[SAMPLE_W-1], ram_rdata} - {cur.median[SAMPLE_W-1], cur.median};
  assign abs_diff = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
  assign kept     = (abs_diff <= {1'b0, max_deviation});

  // A kept sample is held in a pending register so that the last one can carry the end mark.
  assign out_free  = !out_vld || out_stream.ready;
  assign stall     = data_vld && kept && pend_vld && !out_free;
  assign more      = (idx < cur.count);
  assign push_pend = (state == B_RUN) && !stall && data_vld && kept && pend_vld;
  assign push_last = (state == B_FLUSH) && out_free;

  assign job_pop   = (state == B_IDLE) && !job_empty;
  assign ram_re    = (state == B_RUN) && !stall && more;
  assign ram_raddr = {cur.bank, idx[IDX_W-1:0]};
  assign rel.done  = push_last;
  assign rel.bank  = cur.bank;

  // Sequencer over the stored samples of one set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      idx      <= '0;
      data_vld <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_pop) begin
            idx      <= '0;
            data_vld <= 1'b0;
            pend_vld <= 1'b0;
            state    <= B_RUN;
          end
        end
        B_RUN: begin
          if (!stall) begin
            if (data_vld && kept) begin
              pend_vld <= 1'b1;
            end
            if (more) begin
              idx      <= idx + 1'b1;
              data_vld <= 1'b1;
            end else begin
              data_vld <= 1'b0;
              state    <= B_FLUSH;
            end
          end
        end
        B_FLUSH: begin
          if (push_last) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Job and pending sample payload.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if ((state == B_RUN) && !stall && data_vld && kept) begin
      pend_sample <= ram_rdata;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (push_pend || push_last) begin
      out_vld <= 1'b1;
    end else if (out_stream.ready) begin
      out_vld <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_sample <= pend_sample;
      out_median <= cur.median;
      out_eor    <= 1'b0;
      out_nk     <= 1'b0;
      out_ovf    <= cur.ovf;
    end else if (push_last) begin
      out_sample <= pend_vld ? pend_sample : '0;
      out_median <= cur.median;
      out_eor    <= 1'b1;
      out_nk     <= !pend_vld;
      out_ovf    <= cur.ovf;
    end
  end

  assign out_stream.valid        = out_vld;
  assign out_stream.kept_sample  = out_sample;
  assign out_stream.median_value = out_median;
  assign out_stream.end_of_run   = out_eor;
  assign out_stream.none_kept    = out_nk;
  assign out_stream.overflowed   = out_ovf;

endmodule
`default_nettype wire

/* hdl/median_outlier_filter.sv */
// Top level of the median outlier filter.
// Samples of a set are taken one per clock while the loader is ready; after the sample
// marked last, the block reads the median from its sorted register chain in a median
// state that waits while the job queue is full. The set is then read back from the
// arrival store at one stored sample per cycle while the emitter does not stall, with the
// output register holding the pass while the sink stalls. The arrival store has two banks,
// so a new set loads while the previous one is emitted; loading waits only when both banks
// hold sets still being emitted. Sets larger than MAX_SAMPLES keep the first MAX_SAMPLES
// samples and report overflowed. No clearing pass is needed after reset.
`default_nettype none
module median_outlier_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mof_in_if.sink      in_stream,
  mof_out_if.source   out_stream
);
  import mof_pkg::*;

  wr_t       ram_wr;
  job_t      push_job;
  job_t      head_job;
  logic      job_push;
  logic      job_full;
  logic      job_pop;
  logic      job_empty;
  release_t  rel;
  logic      ram_re;
  ram_addr_t ram_raddr;
  sample_t   ram_rdata;

  // Loader.
  mof_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .ram_wr    (ram_wr),
    .job       (push_job),
    .job_push  (job_push),
    .job_full  (job_full),
    .rel       (rel)
  );

  // Queue of loaded sets.
  mof_job_fifo u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .head     (head_job),
    .empty    (job_empty)
  );

  // Two-bank arrival store.
  mof_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_arrival_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Emitter.
  mof_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .job        (head_job),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel        (rel),
    .out_stream (out_stream)
  );

endmodule
`default_nettype wire

/* hdl/mof_checker.sv */
// Port-level checks on the median outlier filter, bound to the top level.
`default_nettype none
module mof_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] kept_sample,
  input logic               end_of_run,
  input logic               none_kept
);

  // A result offered and not taken is still offered in the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A set with no kept sample closes with its single flagged result.
  a_none_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_kept |-> end_of_run)
    else $error("none_kept result without end_of_run");

  // The flagged result carries a zero sample.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_kept |-> (kept_sample == 16'sd0))
    else $error("none_kept result with a non-zero sample");

endmodule

bind median_outlier_filter mof_checker u_mof_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_stream.valid),
  .out_ready   (out_stream.ready),
  .kept_sample (out_stream.kept_sample),
  .end_of_run  (out_stream.end_of_run),
  .none_kept   (out_stream.none_kept)
);
`default_nettype wire
